[src/bte_pkg.sv]
// Shared types, constants and the byte classifier of the byte-level BPE encoder.
// Depends on nothing; every other source file imports it.
package bte_pkg;

    localparam int ID_W   = 13;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam int DEF_MAX_MERGES = 4096;
    localparam int DEF_MAX_CHUNK  = 32;

    localparam logic [ID_W-1:0] FIRST_MERGE_ID = ID_W'(259);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_ORDER     = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDEFINED = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_WORD  = 2'd1,
        CLS_SPACE = 2'd2,
        CLS_OTHER = 2'd3
    } t_cls;

    // Commands from the control sequencer to the chunk encoder
    typedef struct packed {
        logic              start;
        logic              push;
        logic              open;
        logic [BYTE_W-1:0] text;
    } t_enc_cmd;

    // Status and id stream from the chunk encoder
    typedef struct packed {
        logic            idle;
        logic            done;
        logic            id_valid;
        logic [ID_W-1:0] id;
        logic            id_last;
    } t_enc_stat;

    function automatic t_cls byte_class(input logic [BYTE_W-1:0] b);
        t_cls c;
        if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
            (b >= 8'h30 && b <= 8'h39) || b >= 8'h80) begin
            c = CLS_WORD;
        end else if (b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d) begin
            c = CLS_SPACE;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

[src/bte_merge_ram.sv]
// Merge table storage: one write port, one registered read port.
// Depends on bte_pkg for the id width.
module bte_merge_ram import bte_pkg::*; #(
    parameter int DEPTH = DEF_MAX_MERGES,
    parameter int AW    = 12
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic [2*ID_W-1:0]   i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic [2*ID_W-1:0]   o_rdata
);

    logic [2*ID_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

[src/bte_chunk_enc.sv]
// Chunk holder and greedy merge engine: scans the merge table, picks the
// lowest-rank pair, merges, and streams the final ids. Depends on bte_pkg.
module bte_chunk_enc import bte_pkg::*; #(
    parameter int MAX_CHUNK = DEF_MAX_CHUNK,
    parameter int AW        = 12,
    parameter int CNT_W     = 13,
    parameter int LEN_W     = 6,
    parameter int IDX_W     = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_enc_cmd          i_cmd,
    input  logic              i_id_ready,
    input  logic [CNT_W-1:0]  i_count,
    output logic [AW-1:0]     o_raddr,
    input  logic [2*ID_W-1:0] i_rdata,
    output t_enc_stat         o_stat,
    output logic [LEN_W-1:0]  o_len
);

    localparam int NP = MAX_CHUNK - 1;

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_SCAN  = 5'b00010,
        E_PICK  = 5'b00100,
        E_MERGE = 5'b01000,
        E_EMIT  = 5'b10000
    } t_estate;

    t_estate            r_state, n_state;
    logic [ID_W-1:0]    r_ids  [MAX_CHUNK];
    logic [ID_W-1:0]    n_ids  [MAX_CHUNK];
    logic [AW-1:0]      r_rank [NP];
    logic [AW-1:0]      n_rank [NP];
    logic [NP-1:0]      r_hit, n_hit;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic [IDX_W-1:0]   r_p, n_p;
    logic               r_bv, n_bv;
    logic [AW-1:0]      r_best, n_best;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_e, n_e;
    logic               emit_last;
    logic [CNT_W+1:0]   merged_wide;

    assign o_raddr   = r_addr[AW-1:0];
    assign o_len     = r_len;
    assign emit_last = (LEN_W'(r_e) == r_len - LEN_W'(1));
    assign merged_wide = (CNT_W+2)'(FIRST_MERGE_ID) + (CNT_W+2)'(r_best);

    assign o_stat.idle     = (r_state == E_IDLE);
    assign o_stat.id_valid = (r_state == E_EMIT);
    assign o_stat.id       = r_ids[r_e];
    assign o_stat.id_last  = emit_last;
    assign o_stat.done     = (r_state == E_EMIT) && i_id_ready && emit_last;

    always_comb begin
        n_state = r_state;
        n_ids   = r_ids;
        n_rank  = r_rank;
        n_hit   = r_hit;
        n_len   = r_len;
        n_addr  = r_addr;
        n_pend  = 1'b0;
        n_pidx  = r_pidx;
        n_p     = r_p;
        n_bv    = r_bv;
        n_best  = r_best;
        n_pos   = r_pos;
        n_e     = r_e;

        // compare the returning table entry against every adjacent pair
        if (r_pend) begin
            for (int q = 0; q < NP; q++) begin
                if (LEN_W'(q + 1) < r_len && {r_ids[q], r_ids[q+1]} == i_rdata) begin
                    n_hit[q]  = 1'b1;
                    n_rank[q] = r_pidx;
                end
            end
        end

        case (r_state)
            E_IDLE: begin
                if (i_cmd.push) begin
                    n_ids[r_len[IDX_W-1:0]] = ID_W'(i_cmd.text);
                    n_len = r_len + LEN_W'(1);
                end else if (i_cmd.open) begin
                    n_ids[0] = ID_W'(i_cmd.text);
                    n_len    = LEN_W'(1);
                end else if (i_cmd.start) begin
                    n_hit  = '0;
                    n_addr = '0;
                    n_e    = '0;
                    n_state = (r_len > LEN_W'(1)) ? E_SCAN : E_EMIT;
                end
            end
            E_SCAN: begin
                if (r_addr < i_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_addr[AW-1:0];
                    n_addr = r_addr + CNT_W'(1);
                end else if (!r_pend) begin
                    n_p     = '0;
                    n_bv    = 1'b0;
                    n_state = E_PICK;
                end
            end
            E_PICK: begin
                if (r_hit[r_p] && (!r_bv || r_rank[r_p] < r_best)) begin
                    n_bv   = 1'b1;
                    n_best = r_rank[r_p];
                    n_pos  = r_p;
                end
                n_p = r_p + IDX_W'(1);
                if (LEN_W'(r_p) == r_len - LEN_W'(2)) begin
                    n_e     = '0;
                    n_state = n_bv ? E_MERGE : E_EMIT;
                end
            end
            E_MERGE: begin
                for (int q = 0; q < MAX_CHUNK - 1; q++) begin
                    if (IDX_W'(q) == r_pos) begin
                        n_ids[q] = merged_wide[ID_W-1:0];
                    end else if (IDX_W'(q) > r_pos) begin
                        n_ids[q] = r_ids[q+1];
                    end
                end
                n_len  = r_len - LEN_W'(1);
                n_hit  = '0;
                n_addr = '0;
                n_e    = '0;
                n_state = (r_len > LEN_W'(2)) ? E_SCAN : E_EMIT;
            end
            E_EMIT: begin
                if (i_id_ready) begin
                    n_e = r_e + IDX_W'(1);
                    if (emit_last) begin
                        n_len   = '0;
                        n_state = E_IDLE;
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_len   <= '0;
            r_pend  <= 1'b0;
            r_hit   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids  <= n_ids;
        r_rank <= n_rank;
        r_addr <= n_addr;
        r_pidx <= n_pidx;
        r_p    <= n_p;
        r_bv   <= n_bv;
        r_best <= n_best;
        r_pos  <= n_pos;
        r_e    <= n_e;
    end

endmodule

[src/byte_bpe_token_encoder.sv]
// Top level of the byte-level BPE encoder: input control, merge table loading,
// output register. Depends on bte_pkg, bte_merge_ram and bte_chunk_enc.
//
// Clear and append items each give one status result in the cycle after
// acceptance. Text bytes are grouped into chunks (word run with any leading
// space run, lone space runs, single other bytes); a text byte that joins the
// open chunk gives no result unless it is marked last. Closing a chunk of L
// ids runs up to L-1 merge rounds; each round scans every merge held through
// the single read port of the table memory and then walks the L-1 pairs to
// pick the lowest rank, and the final ids are then streamed out. One item is
// worked on at a time; a new item is taken only in the idle state while the
// output register is empty or being read out.
module byte_bpe_token_encoder import bte_pkg::*; #(
    parameter int MAX_MERGES = DEF_MAX_MERGES,
    parameter int MAX_CHUNK  = DEF_MAX_CHUNK
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_text_last,
    input  logic [ID_W-1:0]   i_merge_left,
    input  logic [ID_W-1:0]   i_merge_right,
    input  logic [ID_W-1:0]   i_merge_result,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_result_kind,
    output logic [ID_W-1:0]   o_token_id,
    output logic [ST_W-1:0]   o_load_status,
    output logic              o_run_last
);

    localparam int AW    = (MAX_MERGES > 1) ? $clog2(MAX_MERGES) : 1;
    localparam int CNT_W = $clog2(MAX_MERGES + 1);
    localparam int DEF_W = CNT_W + 2;
    localparam int LEN_W = $clog2(MAX_CHUNK + 1);
    localparam int IDX_W = $clog2(MAX_CHUNK);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CLOSE1 = 4'b0010,
        S_POST   = 4'b0100,
        S_CLOSE2 = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    t_cls               r_prev, n_prev;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    t_cls               r_cls, n_cls;
    logic               r_tlast, n_tlast;
    logic               r_push, n_push;

    logic               r_ov, n_ov;
    logic               r_kind, n_kind;
    logic [ID_W-1:0]    r_tok, n_tok;
    logic [ST_W-1:0]    r_st, n_st;
    logic               r_last, n_last;

    logic               can_load, accept, closing;
    t_cls               cls;
    logic               joins, fits, need_close;
    logic [DEF_W-1:0]   defined;
    logic [ST_W-1:0]    app_status;
    logic               we;
    logic [AW-1:0]      raddr;
    logic [2*ID_W-1:0]  rdata;
    t_enc_cmd           cmd;
    t_enc_stat          est;
    logic [LEN_W-1:0]   enc_len;

    assign can_load   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && can_load;
    assign accept     = i_in_valid && o_in_ready;
    assign closing    = (r_state == S_CLOSE1) || (r_state == S_CLOSE2);

    assign cls        = byte_class(i_text_byte);
    assign joins      = (r_prev == CLS_SPACE) || (r_prev == CLS_WORD && cls == CLS_WORD);
    assign fits       = enc_len < LEN_W'(MAX_CHUNK);
    assign need_close = (r_prev != CLS_NONE) && ((cls == CLS_OTHER) || !(joins && fits));

    // append checks in priority order: order, operands, capacity
    assign defined = DEF_W'(FIRST_MERGE_ID) + DEF_W'(r_count);
    always_comb begin
        if (DEF_W'(i_merge_result) != defined) begin
            app_status = ST_ORDER;
        end else if (DEF_W'(i_merge_left) >= defined || DEF_W'(i_merge_right) >= defined) begin
            app_status = ST_UNDEFINED;
        end else if (r_count >= CNT_W'(MAX_MERGES)) begin
            app_status = ST_FULL;
        end else begin
            app_status = ST_OK;
        end
    end
    assign we = accept && (i_opcode == OP_APPEND) && (app_status == ST_OK);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_prev  = r_prev;
        n_byte  = r_byte;
        n_cls   = r_cls;
        n_tlast = r_tlast;
        n_push  = r_push;
        n_ov    = r_ov && !i_out_ready;
        n_kind  = r_kind;
        n_tok   = r_tok;
        n_st    = r_st;
        n_last  = r_last;
        cmd     = '0;
        cmd.text = r_byte;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ov = 1'b1; n_kind = KIND_STATUS; n_tok = '0;
                            n_st = ST_OK; n_last = 1'b1;
                        end
                        OP_APPEND: begin
                            if (app_status == ST_OK) begin
                                n_count = r_count + CNT_W'(1);
                            end
                            n_ov = 1'b1; n_kind = KIND_STATUS; n_tok = '0;
                            n_st = app_status; n_last = 1'b1;
                        end
                        OP_TEXT: begin
                            n_byte  = i_text_byte;
                            n_cls   = cls;
                            n_tlast = i_text_last;
                            n_push  = (cls != CLS_OTHER) && joins && fits;
                            n_state = need_close ? S_CLOSE1 : S_POST;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_POST: begin
                if (r_cls == CLS_OTHER) begin
                    // other byte is a chunk of its own: pass it straight out
                    if (can_load) begin
                        n_ov = 1'b1; n_kind = KIND_TOKEN; n_tok = ID_W'(r_byte);
                        n_st = ST_OK; n_last = 1'b1;
                        n_prev  = CLS_NONE;
                        n_state = S_IDLE;
                    end
                end else begin
                    cmd.push = r_push;
                    cmd.open = !r_push;
                    n_prev   = r_cls;
                    n_state  = r_tlast ? S_CLOSE2 : S_IDLE;
                end
            end
            S_CLOSE1, S_CLOSE2: begin
                cmd.start = est.idle;
                if (est.id_valid && can_load) begin
                    n_ov = 1'b1; n_kind = KIND_TOKEN; n_tok = est.id; n_st = ST_OK;
                    // more results follow a first close when a byte or a flush trails
                    n_last = est.id_last && ((r_state == S_CLOSE2) ||
                             !((r_cls == CLS_OTHER) || r_tlast));
                end
                if (est.done) begin
                    n_prev  = CLS_NONE;
                    n_state = (r_state == S_CLOSE1) ? S_POST : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_prev  <= CLS_NONE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_prev  <= n_prev;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_cls   <= n_cls;
        r_tlast <= n_tlast;
        r_push  <= n_push;
        r_kind  <= n_kind;
        r_tok   <= n_tok;
        r_st    <= n_st;
        r_last  <= n_last;
    end

    assign o_out_valid   = r_ov;
    assign o_result_kind = r_kind;
    assign o_token_id    = r_tok;
    assign o_load_status = r_st;
    assign o_run_last    = r_last;

    bte_merge_ram #(
        .DEPTH (MAX_MERGES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_merge_left, i_merge_right}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bte_chunk_enc #(
        .MAX_CHUNK (MAX_CHUNK),
        .AW        (AW),
        .CNT_W     (CNT_W),
        .LEN_W     (LEN_W),
        .IDX_W     (IDX_W)
    ) u_enc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_id_ready (closing && can_load),
        .i_count    (r_count),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_stat     (est),
        .o_len      (enc_len)
    );

endmodule
